[rtl/lsch_pkg.sv]
package lsch_pkg;

    localparam int ID_W      = 8;
    localparam int BURST_W   = 16;
    localparam int TICKET_W  = 10;
    localparam int RAND_W    = 31;
    localparam int SUM_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_RANGE = 1'b1;

    localparam logic [CFG_W-1:0] QUANTUM_RST    = 16'd10;
    localparam logic [CFG_W-1:0] DRAW_RANGE_RST = 16'd100;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

[rtl/lottery_scheduler.sv]
// Lottery scheduler.
// Requests arrive on req_valid/req_ready. A load request (mode = 0) appends a
// process entry and gives no response; loads beyond MAX_PROCS are dropped. A
// draw request (mode = 1) gives exactly one response on rsp_valid/rsp_ready
// carrying the picked id, slice start and length and the first_run, finished
// and skipped flags.
// A draw reduces the random value by a bit-serial restoring divider, one bit a
// cycle, then walks the entry tables, one entry per read/compare state pair,
// on a single memory read port, scanning k entries (0 on an empty table, else 1
// up to the entry count) before its last step fills the response register.
// req_ready is low while a draw is in progress.
// The response sits in an output register; a new request is taken while it
// waits, and a draw that finishes while it is still held waits in its last
// step until the receiver takes it.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while
// idle; the block itself does not enforce this.
// Reset clears the entry count, ticket sum, time counter and started marks and
// loads the default quantum and draw range; the entry tables need no clearing.
module lottery_scheduler
    import lsch_pkg::*;
#(
    parameter int MAX_PROCS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 mode,
    input  logic [ID_W-1:0]      process_id,
    input  logic [BURST_W-1:0]   burst_length,
    input  logic [TICKET_W-1:0]  ticket_count,
    input  logic [RAND_W-1:0]    random_value,

    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [ID_W-1:0]      picked_id,
    output logic [TIME_W-1:0]    slice_start,
    output logic [BURST_W-1:0]   slice_length,
    output logic                 first_run,
    output logic                 finished,
    output logic                 skipped
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int DIV_CNT_W = $clog2(RAND_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    // entry tables
    logic [ID_W-1:0]    id_mem        [MAX_PROCS];
    logic [BURST_W-1:0] remaining_mem [MAX_PROCS];
    logic [SUM_W-1:0]   cum_mem       [MAX_PROCS];

    logic [ID_W-1:0]    rd_id_reg;
    logic [BURST_W-1:0] rd_rem_reg;
    logic [SUM_W-1:0]   rd_cum_reg;

    logic [2:0]           state_reg, state_next;
    logic [CFG_W-1:0]     quantum_reg, quantum_next;
    logic [CFG_W-1:0]     draw_range_reg, draw_range_next;
    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic [SUM_W-1:0]     running_sum_reg, running_sum_next;
    logic [TIME_W-1:0]    time_now_reg, time_now_next;
    logic [MAX_PROCS-1:0] started_reg, started_next;
    logic [RAND_W-1:0]    dividend_reg, dividend_next;
    logic [SUM_W-1:0]     div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 hit_reg, hit_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0]      picked_id_reg, picked_id_next;
    logic [TIME_W-1:0]    slice_start_reg, slice_start_next;
    logic [BURST_W-1:0]   slice_length_reg, slice_length_next;
    logic                 first_run_reg, first_run_next;
    logic                 finished_reg, finished_next;
    logic                 skipped_reg, skipped_next;

    logic                 load_we;
    logic                 rem_we;
    logic [BURST_W-1:0]   rem_wdata;

    logic [SUM_W:0]       sum_ext;
    logic [SUM_W:0]       div_trial;
    logic [SUM_W:0]       div_diff;
    logic [SUM_W-1:0]     reduced;
    logic [BURST_W-1:0]   grant_len;
    logic [BURST_W-1:0]   rem_after;
    logic [IDX_W-1:0]     scan_addr;
    logic [IDX_W-1:0]     load_addr;

    assign scan_addr = scan_idx_reg[IDX_W-1:0];
    assign load_addr = entry_count_reg[IDX_W-1:0];

    assign sum_ext   = {1'b0, running_sum_reg} + {{(SUM_W + 1 - TICKET_W){1'b0}}, ticket_count};
    assign div_trial = {div_rem_reg, dividend_reg[RAND_W-1]};
    assign div_diff  = div_trial - {1'b0, draw_range_reg};
    // a zero draw range reduces to zero
    assign reduced   = (draw_range_reg == '0) ? '0 : div_rem_reg;
    assign grant_len = (quantum_reg < rd_rem_reg) ? quantum_reg : rd_rem_reg;
    assign rem_after = rd_rem_reg - grant_len;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        quantum_next      = quantum_reg;
        draw_range_next   = draw_range_reg;
        entry_count_next  = entry_count_reg;
        running_sum_next  = running_sum_reg;
        time_now_next     = time_now_reg;
        started_next      = started_reg;
        dividend_next     = dividend_reg;
        div_rem_next      = div_rem_reg;
        div_cnt_next      = div_cnt_reg;
        scan_idx_next     = scan_idx_reg;
        hit_next          = hit_reg;
        rsp_valid_next    = rsp_valid_reg;
        picked_id_next    = picked_id_reg;
        slice_start_next  = slice_start_reg;
        slice_length_next = slice_length_reg;
        first_run_next    = first_run_reg;
        finished_next     = finished_reg;
        skipped_next      = skipped_reg;
        load_we           = 1'b0;
        rem_we            = 1'b0;
        rem_wdata         = burst_length;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUANTUM:    quantum_next    = cfg_data;
                CFG_DRAW_RANGE: draw_range_next = cfg_data;
                default:        ;
            endcase
        end

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        if (entry_count_reg != CNT_W'(MAX_PROCS))
                        begin
                            load_we          = 1'b1;
                            rem_we           = 1'b1;
                            rem_wdata        = burst_length;
                            running_sum_next = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                            entry_count_next = entry_count_reg + CNT_W'(1);
                            started_next[load_addr] = 1'b0;
                        end
                    end
                    else
                    begin
                        dividend_next = random_value;
                        div_rem_next  = '0;
                        div_cnt_next  = '0;
                        state_next    = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (!div_diff[SUM_W])
                    div_rem_next = div_diff[SUM_W-1:0];
                else
                    div_rem_next = div_trial[SUM_W-1:0];
                dividend_next = {dividend_reg[RAND_W-2:0], 1'b0};
                div_cnt_next  = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(RAND_W - 1))
                begin
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    state_next    = (entry_count_reg == '0) ? ST_FIN : ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                priority if (rd_cum_reg > reduced)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (scan_idx_reg + CNT_W'(1) == entry_count_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    state_next    = ST_READ;
                end
            end

            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next    = 1'b1;
                    picked_id_next    = hit_reg ? rd_id_reg : '0;
                    slice_start_next  = time_now_reg;
                    slice_length_next = '0;
                    first_run_next    = 1'b0;
                    finished_next     = 1'b0;
                    skipped_next      = 1'b1;
                    if (hit_reg && (rd_rem_reg != '0))
                    begin
                        skipped_next      = 1'b0;
                        slice_length_next = grant_len;
                        first_run_next    = ~started_reg[scan_addr];
                        finished_next     = (rem_after == '0);
                        started_next[scan_addr] = 1'b1;
                        rem_we            = 1'b1;
                        rem_wdata         = rem_after;
                        time_now_next     = time_now_reg + {{(TIME_W - BURST_W){1'b0}}, grant_len};
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            quantum_reg     <= QUANTUM_RST;
            draw_range_reg  <= DRAW_RANGE_RST;
            entry_count_reg <= '0;
            running_sum_reg <= '0;
            time_now_reg    <= '0;
            started_reg     <= '0;
            div_cnt_reg     <= '0;
            scan_idx_reg    <= '0;
            hit_reg         <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            quantum_reg     <= quantum_next;
            draw_range_reg  <= draw_range_next;
            entry_count_reg <= entry_count_next;
            running_sum_reg <= running_sum_next;
            time_now_reg    <= time_now_next;
            started_reg     <= started_next;
            div_cnt_reg     <= div_cnt_next;
            scan_idx_reg    <= scan_idx_next;
            hit_reg         <= hit_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg     <= dividend_next;
        div_rem_reg      <= div_rem_next;
        picked_id_reg    <= picked_id_next;
        slice_start_reg  <= slice_start_next;
        slice_length_reg <= slice_length_next;
        first_run_reg    <= first_run_next;
        finished_reg     <= finished_next;
        skipped_reg      <= skipped_next;
    end

    // one write port per table; a load and a slice update never coincide
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            id_mem[load_addr]  <= process_id;
            cum_mem[load_addr] <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        end
        if (rem_we)
            remaining_mem[load_we ? load_addr : scan_addr] <= rem_wdata;
        rd_id_reg  <= id_mem[scan_addr];
        rd_rem_reg <= remaining_mem[scan_addr];
        rd_cum_reg <= cum_mem[scan_addr];
    end

    assign rsp_valid    = rsp_valid_reg;
    assign picked_id    = picked_id_reg;
    assign slice_start  = slice_start_reg;
    assign slice_length = slice_length_reg;
    assign first_run    = first_run_reg;
    assign finished     = finished_reg;
    assign skipped      = skipped_reg;

endmodule

[test/lottery_scheduler_test.sv]
module lottery_scheduler_test;
    import lsch_pkg::*;

    localparam int SLOTS        = 64;
    localparam int HOLD_CYCLES  = 800;
    localparam int TAIL_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 2_000_000;

    typedef struct {
        logic                mode;
        logic [ID_W-1:0]     pid;
        logic [BURST_W-1:0]  burst;
        logic [TICKET_W-1:0] tickets;
        logic [RAND_W-1:0]   rnd;
    } sched_req_t;

    typedef struct {
        logic [ID_W-1:0]    pid;
        logic [TIME_W-1:0]  start;
        logic [BURST_W-1:0] len;
        logic               first;
        logic               done;
        logic               skip;
    } slice_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_QUANTUM;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [ID_W-1:0]      picked_id;
    logic [TIME_W-1:0]    slice_start;
    logic [BURST_W-1:0]   slice_length;
    logic                 first_run;
    logic                 finished;
    logic                 skipped;

    sched_req_t cur_req = '{MODE_LOAD, '0, '0, '0, '0};
    logic                 mode;
    logic [ID_W-1:0]      process_id;
    logic [BURST_W-1:0]   burst_length;
    logic [TICKET_W-1:0]  ticket_count;
    logic [RAND_W-1:0]    random_value;

    assign mode         = cur_req.mode;
    assign process_id   = cur_req.pid;
    assign burst_length = cur_req.burst;
    assign ticket_count = cur_req.tickets;
    assign random_value = cur_req.rnd;

    // scheduler image: process table, ticket total, time counter, registers
    logic [ID_W-1:0]    slot_id      [SLOTS];
    logic [BURST_W-1:0] slot_left    [SLOTS];
    logic [SUM_W-1:0]   slot_cum     [SLOTS];
    logic               slot_started [SLOTS];
    int                 slots_used  = 0;
    logic [SUM_W-1:0]   ticket_sum  = '0;
    logic [TIME_W-1:0]  clock_now   = '0;
    logic [CFG_W-1:0]   cur_quantum = QUANTUM_RST;
    logic [CFG_W-1:0]   cur_range   = DRAW_RANGE_RST;

    sched_req_t pending_reqs [$];
    slice_t     due_slices   [$];

    logic req_fire = 1'b0;
    logic rx_hold = 1'b0;
    logic hold_arm = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   reqs_queued = 0;
    int   reqs_taken = 0;
    int   loads_planned = 0;
    int   loads_kept = 0;
    int   loads_dropped = 0;
    int   draws_seen = 0;
    int   skips = 0;
    int   completions = 0;
    int   checked = 0;
    int   held_stalls = 0;
    int   errors = 0;

    lottery_scheduler #(.MAX_PROCS(SLOTS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .mode         (mode),
        .process_id   (process_id),
        .burst_length (burst_length),
        .ticket_count (ticket_count),
        .random_value (random_value),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .picked_id    (picked_id),
        .slice_start  (slice_start),
        .slice_length (slice_length),
        .first_run    (first_run),
        .finished     (finished),
        .skipped      (skipped)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // applies one accepted request to the image; a draw queues its slice
    function automatic void schedule_request(input sched_req_t r);
        slice_t           s;
        logic [SUM_W-1:0] reduced;
        logic [SUM_W:0]   sum_next;
        int               hit;
        hit = -1;
        if (r.mode == MODE_LOAD)
        begin
            if (slots_used < SLOTS)
            begin
                sum_next = {1'b0, ticket_sum} + {{(SUM_W + 1 - TICKET_W){1'b0}}, r.tickets};
                ticket_sum = sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
                slot_id[slots_used]      = r.pid;
                slot_left[slots_used]    = r.burst;
                slot_cum[slots_used]     = ticket_sum;
                slot_started[slots_used] = 1'b0;
                slots_used++;
                loads_kept++;
            end
            else
                loads_dropped++;
            return;
        end
        draws_seen++;
        // the remainder is below the 16-bit range, so it fits
        reduced = (cur_range != 0) ? SUM_W'(r.rnd % {{(RAND_W - CFG_W){1'b0}}, cur_range}) : '0;
        for (int k = 0; k < slots_used; k++)
            if (hit < 0 && slot_cum[k] > reduced)
                hit = k;
        s.pid   = '0;
        s.start = clock_now;
        s.len   = '0;
        s.first = 1'b0;
        s.done  = 1'b0;
        s.skip  = 1'b0;
        if (hit < 0)
            s.skip = 1'b1;
        else if (slot_left[hit] == 0)
        begin
            s.skip = 1'b1;
            s.pid  = slot_id[hit];
        end
        else
        begin
            s.pid   = slot_id[hit];
            s.first = !slot_started[hit];
            slot_started[hit] = 1'b1;
            s.len   = (cur_quantum < slot_left[hit]) ? cur_quantum : slot_left[hit];
            slot_left[hit] = slot_left[hit] - s.len;
            s.done  = (slot_left[hit] == 0);
            clock_now = clock_now + {{(TIME_W - BURST_W){1'b0}}, s.len};
        end
        if (s.skip)
            skips++;
        if (s.done)
            completions++;
        due_slices.push_back(s);
    endfunction

    function automatic void queue_req(input logic m, input logic [ID_W-1:0] pid,
                                      input logic [BURST_W-1:0] burst,
                                      input logic [TICKET_W-1:0] tix,
                                      input logic [RAND_W-1:0] rnd);
        sched_req_t r;
        r.mode    = m;
        r.pid     = pid;
        r.burst   = burst;
        r.tickets = tix;
        r.rnd     = rnd;
        pending_reqs.push_back(r);
        reqs_queued++;
        if (m == MODE_LOAD)
            loads_planned++;
    endfunction

    // mostly draws; loads trickle in until the table is full, then become noise
    task automatic queue_random(input int amount);
        int                 counted;
        logic               m;
        logic [BURST_W-1:0] b;
        counted = 0;
        while (counted < amount)
        begin
            m = ($urandom_range(loads_planned < SLOTS ? 15 : 39) == 0) ? MODE_LOAD : MODE_DRAW;
            case ($urandom_range(15))
                0:       b = '0;
                1, 2:    b = BURST_W'($urandom_range(16'hFFFF));
                default: b = BURST_W'($urandom_range(1, 60));
            endcase
            if (m == MODE_DRAW || loads_planned < SLOTS)
                counted++;
            queue_req(m, ID_W'($urandom_range(255)), b, TICKET_W'($urandom_range(1023)),
                      RAND_W'($urandom_range(31'h7FFF_FFFF)));
        end
    endtask

    function automatic logic [CFG_W-1:0] range_near_sum(input int slack);
        int v;
        v = int'(ticket_sum) + int'($urandom_range(slack));
        if (v < 1)
            v = 1;
        if (v > 65535)
            v = 65535;
        return v[CFG_W-1:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_QUANTUM)
            cur_quantum = val;
        else
            cur_range = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle(input int extra);
        while (reqs_taken != reqs_queued || due_slices.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] q, input logic [CFG_W-1:0] dr,
                             input int sp, input int rp, input int amount);
        write_reg(CFG_QUANTUM, q);
        write_reg(CFG_DRAW_RANGE, dr);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        queue_random(amount);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_req   <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        rsp_ready <= rst_n && !rx_hold && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : watch
        slice_t want;
        req_fire <= req_valid && req_ready;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                schedule_request(cur_req);
                reqs_taken++;
            end
            if (rx_hold && req_valid && !req_ready)
                held_stalls++;
            if (rsp_valid && rsp_ready)
            begin
                if (due_slices.size() == 0)
                    note_error($sformatf("unexpected response: id=%0d start=%0d len=%0d",
                                         picked_id, slice_start, slice_length));
                else
                begin
                    want = due_slices.pop_front();
                    checked++;
                    if (want.pid != picked_id || want.start != slice_start ||
                        want.len != slice_length || want.first != first_run ||
                        want.done != finished || want.skip != skipped)
                        note_error($sformatf({"response %0d mismatch: expected id=%0d ",
                            "start=%0d len=%0d first=%0b fin=%0b skip=%0b, got id=%0d ",
                            "start=%0d len=%0d first=%0b fin=%0b skip=%0b"}, checked,
                            want.pid, want.start, want.len, want.first, want.done,
                            want.skip, picked_id, slice_start, slice_length, first_run,
                            finished, skipped));
                end
            end
        end
    end

    // long receiver hold so the output register and the next draw back up
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("timed out with %0d responses outstanding", due_slices.size());
        $display("lottery_scheduler_test: FAIL");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table: nothing can match
        queue_req(MODE_DRAW, '0, '0, '0, '0);
        queue_req(MODE_DRAW, 8'hFF, 16'hFFFF, 10'h3FF, 31'h7FFF_FFFF);
        queue_req(MODE_LOAD, 8'h00, 16'd25, 10'd1, '0);
        queue_req(MODE_LOAD, 8'hFF, 16'd0, 10'd0, 31'h7FFF_FFFF);  // no tickets
        queue_req(MODE_LOAD, 8'h3C, 16'd0, 10'd50, '0);            // loaded finished
        queue_req(MODE_LOAD, 8'hC3, 16'hFFFF, 10'h3FF, '0);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd0);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd100);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd1);
        queue_req(MODE_DRAW, '0, '0, '0, 31'h7FFF_FFFF);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd151);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd99);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd200);                 // first entry runs out
        queue_req(MODE_DRAW, '0, '0, '0, 31'd0);
        settle(8);

        // zero quantum still marks the process as started
        write_reg(CFG_QUANTUM, '0);
        write_reg(CFG_DRAW_RANGE, 16'hFFFF);
        queue_req(MODE_LOAD, 8'h81, 16'd7, 10'd512, '0);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd1500);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd1500);
        queue_req(MODE_DRAW, '0, '0, '0, 31'd65534);
        settle(8);

        run_phase(16'd1, 16'd1, 85, 0, 50);
        settle(8);
        run_phase(CFG_W'($urandom_range(2, 12)), range_near_sum(64), 0, 85, 300);
        settle(8);
        run_phase('0, 16'hFFFF, 11, 11, 100);
        settle(8);
        run_phase(CFG_W'($urandom_range(1, 40)), '0, 0, 0, 50);
        settle(8);
        run_phase(CFG_W'($urandom_range(1, 20)), range_near_sum(256), 85, 0, 350);
        settle(8);
        run_phase(16'd10, range_near_sum(0), 0, 85, 350);
        hold_arm = 1'b1;
        settle(8);
        run_phase(CFG_W'($urandom_range(5, 50)), range_near_sum(32), 11, 11, 300);
        settle(8);
        run_phase(16'hFFFF, range_near_sum(0), 0, 0, 50);
        settle(TAIL_CYCLES);

        $display("%0d requests: %0d loads stored, %0d dropped on a full table, %0d draws",
                 reqs_taken, loads_kept, loads_dropped, draws_seen);
        $display("%0d responses checked, %0d skipped, %0d ran to completion; %0d cycles stalled",
                 checked, skips, completions, held_stalls);
        if (errors == 0)
            $display("lottery_scheduler_test: PASS");
        else
        begin
            $display("%0d errors", errors);
            $display("lottery_scheduler_test: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/lsch_pkg.sv
rtl/lottery_scheduler.sv
test/lottery_scheduler_test.sv
